FILE: rtl/spw_pkg.sv
`timescale 1ns / 1ps
package spw_pkg;

  localparam int unsigned MaxKeyBytesDefault = 256;
  localparam int unsigned DigitCount = 20;
  localparam int unsigned DigestBytes = 20;

  localparam logic CMD_APPEND = 1'b0;
  localparam logic CMD_EVAL   = 1'b1;

  typedef struct packed {
    logic        command;
    logic [7:0]  key_byte;
    logic        start_new_key;
    logic [63:0] counter;
  } spw_in_t;

  typedef struct packed {
    logic [7:0] security_level;
    logic       key_truncated;
  } spw_out_t;

  // controller to datapath
  typedef struct packed {
    logic       append;
    logic       conv_init;
    logic       conv_step;
    logic       prep;
    logic       load_rd;
    logic       load_sh;
    logic       rnd_init;
    logic       rnd_step;
    logic [6:0] rnd_idx;
    logic       fold;
    logic       scan_init;
    logic       scan_step;
  } spw_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic blocks_done;
  } spw_sts_t;

  function automatic logic [31:0] rol32(input logic [31:0] x, input int unsigned n);
    rol32 = (x << n) | (x >> (32 - n));
  endfunction

endpackage

FILE: rtl/sha1_proof_of_work_level_top.sv
`timescale 1ns / 1ps
// channel  ports                         transfer
// input    start, busy, in_item          start high and busy low at a rising edge
// result   out_valid, out_item           out_valid high for one cycle, always taken
//
// an append leaves busy low
// an evaluation hashes one to five blocks (default MAX_KEY_BYTES) through the
// 80-round sha-1 loop, loading each block through the byte-wide key memory port
// reset is synchronous and clears the key length and truncation flag
// results cannot be stalled: each one shows for exactly one cycle
module sha1_proof_of_work_level_top
  import spw_pkg::*;
#(
  parameter int unsigned MAX_KEY_BYTES = MaxKeyBytesDefault
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  spw_in_t  in_item,
  output logic     out_valid,
  output spw_out_t out_item
);

  spw_cmd_t cmd;
  spw_sts_t sts;

  // sequencer
  spw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_item   (in_item),
    .sts       (sts),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  // key store, decimal conversion and hash datapath
  spw_dp #(
    .MAX_KEY_BYTES (MAX_KEY_BYTES)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_item),
    .cmd      (cmd),
    .sts      (sts),
    .out_item (out_item)
  );

endmodule

FILE: rtl/spw_ctrl.sv
`timescale 1ns / 1ps
module spw_ctrl
  import spw_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  spw_in_t  in_item,
  input  spw_sts_t sts,
  output logic     busy,
  output logic     out_valid,
  output spw_cmd_t cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CONV  = 3'd1;
  localparam logic [2:0] S_PREP  = 3'd2;
  localparam logic [2:0] S_LOAD  = 3'd3;
  localparam logic [2:0] S_ROUND = 3'd4;
  localparam logic [2:0] S_FOLD  = 3'd5;
  localparam logic [2:0] S_SCAN  = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic [6:0] cnt_r, cnt_nxt;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    cmd.rnd_idx = cnt_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          if (in_item.command == CMD_APPEND) begin
            cmd.append = 1'b1;
          end else begin
            cmd.conv_init = 1'b1;
            cnt_nxt = '0;
            state_nxt = S_CONV;
          end
        end
      end
      S_CONV: begin
        cmd.conv_step = 1'b1;
        cnt_nxt = cnt_r + 7'd1;
        if (cnt_r == 7'd63) begin
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        cmd.prep = 1'b1;
        cnt_nxt = '0;
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        cmd.load_rd = (cnt_r != 7'd64);
        cmd.load_sh = (cnt_r != 7'd0);
        cnt_nxt = cnt_r + 7'd1;
        if (cnt_r == 7'd64) begin
          cmd.rnd_init = 1'b1;
          cnt_nxt = '0;
          state_nxt = S_ROUND;
        end
      end
      S_ROUND: begin
        cmd.rnd_step = 1'b1;
        cnt_nxt = cnt_r + 7'd1;
        if (cnt_r == 7'd79) begin
          state_nxt = S_FOLD;
        end
      end
      S_FOLD: begin
        cmd.fold = 1'b1;
        cnt_nxt = '0;
        state_nxt = sts.blocks_done ? S_SCAN : S_LOAD;
        cmd.scan_init = sts.blocks_done;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        cnt_nxt = cnt_r + 7'd1;
        if (cnt_r == 7'(DigestBytes - 1)) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);

endmodule

FILE: rtl/spw_dp.sv
`timescale 1ns / 1ps
module spw_dp
  import spw_pkg::*;
#(
  parameter int unsigned MAX_KEY_BYTES = MaxKeyBytesDefault
) (
  input  logic     clk,
  input  logic     rst_n,
  input  spw_in_t  in_item,
  input  spw_cmd_t cmd,
  output spw_sts_t sts,
  output spw_out_t out_item
);

  localparam int unsigned AW  = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
  localparam int unsigned KLW = $clog2(MAX_KEY_BYTES + 1);
  localparam int unsigned PW  = $clog2(MAX_KEY_BYTES + DigitCount + 72 + 1);
  localparam int unsigned BW  = PW - 5;

  // key store and its fill state
  logic [7:0]     mem [MAX_KEY_BYTES];
  logic [7:0]     mem_q_r;
  logic [KLW-1:0] klen_r;
  logic           ovf_r;
  logic [AW-1:0]  wr_addr;
  logic           wr_en;

  always_comb begin
    wr_addr = klen_r[AW-1:0];
    wr_en   = 1'b0;
    if (cmd.append) begin
      if (in_item.start_new_key) begin
        wr_addr = '0;
        wr_en   = 1'b1;
      end else begin
        wr_en = (klen_r < KLW'(MAX_KEY_BYTES));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      klen_r <= '0;
      ovf_r  <= 1'b0;
    end else if (cmd.append) begin
      if (in_item.start_new_key) begin
        klen_r <= KLW'(1);
        ovf_r  <= 1'b0;
      end else if (wr_en) begin
        klen_r <= klen_r + KLW'(1);
      end else begin
        ovf_r <= 1'b1;
      end
    end
  end

  // memory port: one write, one registered read
  logic [PW-1:0] pos_r;
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= in_item.key_byte;
    end
    mem_q_r <= mem[pos_r[AW-1:0]];
  end

  // binary to bcd, one bit per cycle
  logic [63:0]             bin_r;
  logic [4*DigitCount-1:0] bcd_r;
  logic [4*DigitCount-1:0] bcd_adj;

  always_comb begin
    for (int j = 0; j < DigitCount; j++) begin
      bcd_adj[4*j +: 4] = (bcd_r[4*j +: 4] >= 4'd5) ? bcd_r[4*j +: 4] + 4'd3
                                                     : bcd_r[4*j +: 4];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.conv_init) begin
      bin_r <= in_item.counter;
      bcd_r <= '0;
    end else if (cmd.conv_step) begin
      bin_r <= {bin_r[62:0], 1'b0};
      bcd_r <= {bcd_adj[4*DigitCount-2:0], bin_r[63]};
    end
  end

  // digit count, at least one
  logic [4:0] nd;
  always_comb begin
    nd = 5'd1;
    for (int j = 0; j < DigitCount; j++) begin
      if (bcd_r[4*j +: 4] != 4'd0) begin
        nd = 5'(j + 1);
      end
    end
  end

  logic [PW-1:0] len_r;
  logic [BW-1:0] nblk;
  logic [PW-1:0] len_p8;

  assign len_p8 = len_r + PW'(8);
  assign nblk   = BW'(len_p8 >> 6) + BW'(1);

  // message byte stream
  logic [PW-1:0]  pos_d_r;
  logic [PW-1:0]  dig_idx;
  logic [63:0]    bitlen;
  logic [7:0]     msg_byte;
  logic           final_blk;
  logic [5:0]     off;
  logic [3:0]     dsel;

  assign dig_idx   = len_r - PW'(1) - pos_d_r;
  assign bitlen    = 64'(len_r) << 3;
  assign off       = pos_d_r[5:0];
  assign final_blk = (BW'(pos_d_r >> 6) == nblk - BW'(1));
  assign dsel      = bcd_r[4*dig_idx[4:0] +: 4];

  always_comb begin
    msg_byte = 8'h00;
    priority if (pos_d_r < PW'(klen_r)) begin
      msg_byte = mem_q_r;
    end else if (pos_d_r < len_r) begin
      msg_byte = {4'h3, dsel};
    end else if (pos_d_r == len_r) begin
      msg_byte = 8'h80;
    end else if (final_blk && off >= 6'd56) begin
      msg_byte = bitlen[8*(63 - off[2:0] - 56 + 56 - 56) +: 8];
    end else begin
      msg_byte = 8'h00;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      len_r <= PW'(klen_r) + PW'(nd);
      pos_r <= '0;
    end else if (cmd.load_rd) begin
      pos_r <= pos_r + PW'(1);
    end
    if (cmd.load_rd) begin
      pos_d_r <= pos_r;
    end
  end

  // message schedule window and round state
  logic [511:0] blk_r;
  logic [31:0]  h_r [5];
  logic [31:0]  a_r, b_r, c_r, d_r, e_r;
  logic [31:0]  w_new, f, k, t;

  assign w_new = rol32(blk_r[511-32*13 -: 32] ^ blk_r[511-32*8 -: 32] ^
                       blk_r[511-32*2 -: 32] ^ blk_r[511 -: 32], 1);

  always_comb begin
    if (cmd.rnd_idx < 7'd20) begin
      f = (b_r & c_r) | (~b_r & d_r);
      k = 32'h5A827999;
    end else if (cmd.rnd_idx < 7'd40) begin
      f = b_r ^ c_r ^ d_r;
      k = 32'h6ED9EBA1;
    end else if (cmd.rnd_idx < 7'd60) begin
      f = (b_r & c_r) | (b_r & d_r) | (c_r & d_r);
      k = 32'h8F1BBCDC;
    end else begin
      f = b_r ^ c_r ^ d_r;
      k = 32'hCA62C1D6;
    end
    t = rol32(a_r, 5) + f + e_r + k + blk_r[511 -: 32];
  end

  always_ff @(posedge clk) begin
    if (cmd.conv_init) begin
      h_r[0] <= 32'h67452301;
      h_r[1] <= 32'hEFCDAB89;
      h_r[2] <= 32'h98BADCFE;
      h_r[3] <= 32'h10325476;
      h_r[4] <= 32'hC3D2E1F0;
    end else if (cmd.fold) begin
      h_r[0] <= h_r[0] + a_r;
      h_r[1] <= h_r[1] + b_r;
      h_r[2] <= h_r[2] + c_r;
      h_r[3] <= h_r[3] + d_r;
      h_r[4] <= h_r[4] + e_r;
    end
    if (cmd.load_sh) begin
      blk_r <= {blk_r[503:0], msg_byte};
    end else if (cmd.rnd_step) begin
      blk_r <= {blk_r[479:0], w_new};
    end
    if (cmd.rnd_init) begin
      a_r <= h_r[0];
      b_r <= h_r[1];
      c_r <= h_r[2];
      d_r <= h_r[3];
      e_r <= h_r[4];
    end else if (cmd.rnd_step) begin
      e_r <= d_r;
      d_r <= c_r;
      c_r <= rol32(b_r, 30);
      b_r <= a_r;
      a_r <= t;
    end
  end

  assign sts.blocks_done = (BW'(pos_r >> 6) == nblk);

  // level scan, one digest byte per cycle
  logic [159:0] dg_r;
  logic [7:0]   lvl_r;
  logic         found_r;
  logic [7:0]   top;
  logic [3:0]   tz;

  assign top = dg_r[159:152];

  always_comb begin
    tz = 4'd0;
    for (int i = 7; i >= 0; i--) begin
      if (top[i]) begin
        tz = 4'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_init) begin
      dg_r    <= {h_r[0] + a_r, h_r[1] + b_r, h_r[2] + c_r, h_r[3] + d_r, h_r[4] + e_r};
      lvl_r   <= '0;
      found_r <= 1'b0;
    end else if (cmd.scan_step) begin
      dg_r <= {dg_r[151:0], 8'h00};
      if (!found_r) begin
        if (top == 8'h00) begin
          lvl_r <= lvl_r + 8'd8;
        end else begin
          lvl_r   <= lvl_r + 8'(tz);
          found_r <= 1'b1;
        end
      end
    end
  end

  assign out_item.security_level = lvl_r;
  assign out_item.key_truncated  = ovf_r;

endmodule
